[rtl/core/tccw_pkg.sv]
// Shared definitions for the text console character writer.
// Field widths, character codes, register indexes, attribute swap and the
// command/status types between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package tccw_pkg;

	// default screen geometry
	localparam int TCCW_ROWS     = 25;
	localparam int TCCW_COLS     = 80;
	localparam int TCCW_TAB_STOP = 8;

	// field widths
	localparam int CHAR_W     = 8;
	localparam int INDEX_W    = 11;
	localparam int DATA_W     = 16;
	localparam int ATTR_W     = 8;
	localparam int ROW_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHAR_ATTR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_ATTR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_TOP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_BOT  = 2'd3;

	// register reset values
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
	localparam logic [ROW_W-1:0]  TOP_RESET  = 5'd0;
	localparam logic [ROW_W-1:0]  BOT_RESET  = 5'd24;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// attribute nibble masks
	localparam logic [ATTR_W-1:0] ATTR_KEEP_MASK = 8'h88;
	localparam logic [ATTR_W-1:0] ATTR_HI_MASK   = 8'h70;
	localparam logic [ATTR_W-1:0] ATTR_LO_MASK   = 8'h07;

	// what the latched word asks for
	typedef enum logic [2:0] {
		KIND_READ,
		KIND_PRINT,
		KIND_MOVE,
		KIND_FILL,
		KIND_NONE
	} tccw_kind_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic ctr_zero;
		logic clear;
		logic fill;
		logic cur_home;
		logic wrap;
		logic sw_read;
		logic sw_write;
		logic sc_setup;
		logic copy;
		logic blank_setup;
		logic blank;
		logic sc_adj;
		logic load_out;
	} tccw_cmd_t;

	// datapath to controller
	typedef struct packed {
		tccw_kind_t kind;
		logic       col_wrap;
		logic       cur_oob;
		logic       ctr_last;
		logic       top_lt_bot;
		logic       bot_in;
		logic       out_free;
	} tccw_stat_t;

	// fg/bg swap: bits 7 and 3 stay, 6..4 and 2..0 trade places
	function automatic logic [ATTR_W-1:0] swap_attr(input logic [ATTR_W-1:0] a);
		return (a & ATTR_KEEP_MASK) | ((a & ATTR_HI_MASK) >> 4) | ((a & ATTR_LO_MASK) << 4);
	endfunction

endpackage

[rtl/core/tccw_in_if.sv]
// Request channel of the text console character writer.
// Valid/ready handshake with action, character and cell index; uses tccw_pkg.
`timescale 1ns / 1ps

interface tccw_in_if import tccw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               action;
	logic [CHAR_W-1:0]  char_code;
	logic [INDEX_W-1:0] cell_index;

	modport source (output valid, action, char_code, cell_index, input ready);
	modport sink   (input valid, action, char_code, cell_index, output ready);
endinterface

[rtl/core/tccw_out_if.sv]
// Result channel of the text console character writer.
// Valid/ready handshake with cell data, cursor position and beep; uses tccw_pkg.
`timescale 1ns / 1ps

interface tccw_out_if import tccw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  read_data;
	logic [INDEX_W-1:0] cursor_pos;
	logic               beep;

	modport source (output valid, read_data, cursor_pos, beep, input ready);
	modport sink   (input valid, read_data, cursor_pos, beep, output ready);
endinterface

[rtl/core/tccw_ctrl.sv]
// Sequencer of the text console character writer.
// Steps each word through decode, fill, cursor update, scroll and swap; uses tccw_pkg.
`timescale 1ns / 1ps

module tccw_ctrl import tccw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  tccw_stat_t stat,
	output tccw_cmd_t  cmd
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_EXEC  = 4'd2;
	localparam logic [3:0] S_FILL  = 4'd3;
	localparam logic [3:0] S_NORM  = 4'd4;
	localparam logic [3:0] S_SCSET = 4'd5;
	localparam logic [3:0] S_COPY  = 4'd6;
	localparam logic [3:0] S_BLSET = 4'd7;
	localparam logic [3:0] S_BLANK = 4'd8;
	localparam logic [3:0] S_SCADJ = 4'd9;
	localparam logic [3:0] S_SWWR  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.ctr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				case (stat.kind)
					KIND_PRINT, KIND_MOVE: state_d = S_NORM;
					KIND_FILL: begin
						cmd.ctr_zero = 1'b1;
						state_d      = S_FILL;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.ctr_last) begin
					cmd.cur_home = 1'b1;
					state_d      = S_NORM;
				end
			end
			// fold column overflow into rows, then check for scroll
			S_NORM: begin
				if (stat.col_wrap) begin
					cmd.wrap = 1'b1;
				end else if (stat.cur_oob) begin
					state_d = S_SCSET;
				end else begin
					cmd.sw_read = 1'b1;
					state_d     = S_SWWR;
				end
			end
			S_SCSET: begin
				cmd.sc_setup = 1'b1;
				state_d      = stat.top_lt_bot ? S_COPY : S_BLSET;
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				if (stat.ctr_last) state_d = S_BLSET;
			end
			S_BLSET: begin
				cmd.blank_setup = 1'b1;
				state_d         = stat.bot_in ? S_BLANK : S_SCADJ;
			end
			S_BLANK: begin
				cmd.blank = 1'b1;
				if (stat.ctr_last) state_d = S_SCADJ;
			end
			S_SCADJ: begin
				cmd.sc_adj = 1'b1;
				state_d    = S_NORM;
			end
			S_SWWR: begin
				cmd.sw_write = 1'b1;
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/tccw_dpath.sv]
// Datapath of the text console character writer: screen memory, cursor,
// walk counter, configuration and result register; uses tccw_pkg.
`timescale 1ns / 1ps

module tccw_dpath import tccw_pkg::*; #(
	parameter int ROWS     = TCCW_ROWS,
	parameter int COLS     = TCCW_COLS,
	parameter int TAB_STOP = TCCW_TAB_STOP
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tccw_cmd_t             cmd,
	output tccw_stat_t            stat,
	input  logic                  in_action,
	input  logic [CHAR_W-1:0]     in_char,
	input  logic [INDEX_W-1:0]    in_index,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [DATA_W-1:0]     out_data,
	output logic [INDEX_W-1:0]    out_cursor,
	output logic                  out_beep
);

	localparam int CELLS  = ROWS * COLS;
	localparam int AW     = $clog2(CELLS);
	localparam int CW_RAW = $clog2(CELLS + COLS + TAB_STOP);
	localparam int CW     = (CW_RAW > INDEX_W) ? CW_RAW : INDEX_W;
	localparam int CLW    = $clog2(COLS + TAB_STOP);
	localparam int TW     = $clog2(TAB_STOP);
	localparam int TW1    = TW + 1;
	localparam int RMAX   = (ROWS > 32) ? ROWS : 32;
	localparam int PW     = $clog2(RMAX * COLS + COLS);
	localparam int CM     = COLS % TAB_STOP;

	localparam logic [CW-1:0] COLS_C  = CW'(COLS);
	localparam logic [CW-1:0] CELLS_C = CW'(CELLS);
	localparam logic [PW-1:0] COLS_P  = PW'(COLS);
	localparam logic [PW-1:0] CELLS_P = PW'(CELLS);

	// screen memory
	logic [DATA_W-1:0] scr_mem [CELLS];
	logic [DATA_W-1:0] rd_q;

	// configuration
	logic [ATTR_W-1:0] char_attr_q;
	logic [ATTR_W-1:0] norm_attr_q;
	logic [ROW_W-1:0]  top_q;
	logic [ROW_W-1:0]  bot_q;

	// latched word
	logic               act_q;
	logic [CHAR_W-1:0]  chr_q;
	logic [INDEX_W-1:0] idx_q;

	// cursor: linear index, row start, column, and both modulo tab stop
	logic [CW-1:0]  cursor_q;
	logic [CW-1:0]  base_q;
	logic [CLW-1:0] col_q;
	logic [TW-1:0]  phase_q;
	logic [TW-1:0]  bphase_q;

	// walk counter and copy write stage
	logic [PW-1:0] ctr_q;
	logic [PW-1:0] end_q;
	logic          cp_vld_q;
	logic [AW-1:0] cp_addr_q;

	// result register
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;
	logic [INDEX_W-1:0] out_cursor_q;
	logic               out_beep_q;

	tccw_kind_t        kind;
	logic [CW-1:0]     idx_ext;
	logic [CW-1:0]     in_idx_ext;
	logic [PW-1:0]     src;
	logic [PW-1:0]     top_base;
	logic [PW-1:0]     bot_base;
	logic [TW1-1:0]    tab_step;
	logic [DATA_W-1:0] swapped;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;

	function automatic logic [TW-1:0] ph_inc(input logic [TW-1:0] x);
		return (x == TW'(TAB_STOP - 1)) ? '0 : x + TW'(1);
	endfunction

	function automatic logic [TW-1:0] ph_dec(input logic [TW-1:0] x);
		return (x == '0) ? TW'(TAB_STOP - 1) : x - TW'(1);
	endfunction

	// add COLS modulo the tab stop
	function automatic logic [TW-1:0] ph_add(input logic [TW-1:0] x);
		logic [TW1-1:0] s;
		s = {1'b0, x} + TW1'(CM);
		if (s >= TW1'(TAB_STOP)) s = s - TW1'(TAB_STOP);
		return s[TW-1:0];
	endfunction

	// subtract COLS modulo the tab stop
	function automatic logic [TW-1:0] ph_sub(input logic [TW-1:0] x);
		logic [TW1-1:0] s;
		if ({1'b0, x} >= TW1'(CM)) s = {1'b0, x} - TW1'(CM);
		else s = {1'b0, x} + TW1'(TAB_STOP) - TW1'(CM);
		return s[TW-1:0];
	endfunction

	assign idx_ext    = CW'(idx_q);
	assign in_idx_ext = CW'(in_index);
	assign src        = ctr_q + COLS_P;
	assign top_base   = PW'(top_q) * COLS_P;
	assign bot_base   = PW'(bot_q) * COLS_P;
	assign tab_step   = TW1'(TAB_STOP) - {1'b0, phase_q};
	assign swapped    = {swap_attr(rd_q[DATA_W-1:CHAR_W]), rd_q[CHAR_W-1:0]};

	// decode of the latched word
	always_comb begin
		if (act_q) begin
			kind = KIND_READ;
		end else if (chr_q >= CH_SPACE) begin
			kind = KIND_PRINT;
		end else if (chr_q inside {CH_LF, CH_CR, CH_TAB}) begin
			kind = KIND_MOVE;
		end else if (chr_q == CH_BS && cursor_q != '0) begin
			kind = KIND_MOVE;
		end else if (chr_q == CH_FF) begin
			kind = KIND_FILL;
		end else begin
			kind = KIND_NONE;
		end
	end

	// status to the controller
	always_comb begin
		stat.kind       = kind;
		stat.col_wrap   = col_q >= CLW'(COLS);
		stat.cur_oob    = cursor_q >= CELLS_C;
		stat.ctr_last   = ctr_q == end_q;
		stat.top_lt_bot = top_q < bot_q;
		stat.bot_in     = PW'(bot_q) < PW'(ROWS);
		stat.out_free   = !out_valid_q || out_ready;
	end

	// memory read port select
	always_comb begin
		rd_en = cmd.take || cmd.sw_read || cmd.copy;
		if (cmd.take) begin
			rd_addr = in_action ? in_idx_ext[AW-1:0] : cursor_q[AW-1:0];
		end else if (cmd.sw_read) begin
			rd_addr = cursor_q[AW-1:0];
		end else begin
			rd_addr = src[AW-1:0];
		end
	end

	// memory write port select; the copy stage never overlaps another writer
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cursor_q[AW-1:0];
		wr_data = '0;
		if (cp_vld_q) begin
			wr_en   = 1'b1;
			wr_addr = cp_addr_q;
			wr_data = rd_q;
		end else if (cmd.exec && kind == KIND_PRINT) begin
			wr_en   = 1'b1;
			wr_data = {char_attr_q, chr_q};
		end else if (cmd.exec && kind == KIND_MOVE) begin
			wr_en   = 1'b1;
			wr_data = swapped;
		end else if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = ctr_q[AW-1:0];
		end else if (cmd.fill) begin
			wr_en   = 1'b1;
			wr_addr = ctr_q[AW-1:0];
			wr_data = {char_attr_q, CH_SPACE};
		end else if (cmd.blank) begin
			wr_en   = 1'b1;
			wr_addr = ctr_q[AW-1:0];
			wr_data = {norm_attr_q, CH_SPACE};
		end else if (cmd.sw_write) begin
			wr_en   = 1'b1;
			wr_data = swapped;
		end
	end

	// screen memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) scr_mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= scr_mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_attr_q <= ATTR_RESET;
			norm_attr_q <= ATTR_RESET;
			top_q       <= TOP_RESET;
			bot_q       <= BOT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_CHAR_ATTR:   char_attr_q <= cfg_data;
				REG_NORMAL_ATTR: norm_attr_q <= cfg_data;
				REG_SCROLL_TOP:  top_q       <= cfg_data[ROW_W-1:0];
				REG_SCROLL_BOT:  bot_q       <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// word latch
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			act_q <= in_action;
			chr_q <= in_char;
			idx_q <= in_index;
		end
	end

	// cursor update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			base_q   <= '0;
			col_q    <= '0;
			phase_q  <= '0;
			bphase_q <= '0;
		end else if (cmd.exec && kind == KIND_PRINT) begin
			cursor_q <= cursor_q + CW'(1);
			col_q    <= col_q + CLW'(1);
			phase_q  <= ph_inc(phase_q);
		end else if (cmd.exec && kind == KIND_MOVE) begin
			case (chr_q)
				CH_LF: begin
					cursor_q <= cursor_q + COLS_C;
					base_q   <= base_q + COLS_C;
					phase_q  <= ph_add(phase_q);
					bphase_q <= ph_add(bphase_q);
				end
				CH_CR: begin
					cursor_q <= base_q;
					col_q    <= '0;
					phase_q  <= bphase_q;
				end
				CH_TAB: begin
					cursor_q <= cursor_q + CW'(tab_step);
					col_q    <= col_q + CLW'(tab_step);
					phase_q  <= '0;
				end
				// backspace
				default: begin
					cursor_q <= cursor_q - CW'(1);
					phase_q  <= ph_dec(phase_q);
					if (col_q == '0) begin
						col_q    <= CLW'(COLS - 1);
						base_q   <= base_q - COLS_C;
						bphase_q <= ph_sub(bphase_q);
					end else begin
						col_q <= col_q - CLW'(1);
					end
				end
			endcase
		end else if (cmd.cur_home) begin
			cursor_q <= '0;
			base_q   <= '0;
			col_q    <= '0;
			phase_q  <= '0;
			bphase_q <= '0;
		end else if (cmd.wrap) begin
			col_q    <= col_q - CLW'(COLS);
			base_q   <= base_q + COLS_C;
			bphase_q <= ph_add(bphase_q);
		end else if (cmd.sc_adj) begin
			cursor_q <= cursor_q - COLS_C;
			base_q   <= base_q - COLS_C;
			phase_q  <= ph_sub(phase_q);
			bphase_q <= ph_sub(bphase_q);
		end
	end

	// walk counter; starts on the reset clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			end_q <= CELLS_P - PW'(1);
		end else if (cmd.ctr_zero) begin
			ctr_q <= '0;
			end_q <= CELLS_P - PW'(1);
		end else if (cmd.sc_setup) begin
			ctr_q <= top_base;
			end_q <= bot_base - PW'(1);
		end else if (cmd.blank_setup) begin
			ctr_q <= bot_base;
			end_q <= bot_base + COLS_P - PW'(1);
		end else if (cmd.clear || cmd.fill || cmd.copy || cmd.blank) begin
			ctr_q <= ctr_q + PW'(1);
		end
	end

	// copy write stage: data lands in rd_q, written one row up next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_vld_q <= 1'b0;
		end else begin
			cp_vld_q <= cmd.copy && (src < CELLS_P);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.copy) cp_addr_q <= ctr_q[AW-1:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q   <= (act_q && idx_ext < CELLS_C) ? rd_q : '0;
			out_cursor_q <= cursor_q[INDEX_W-1:0];
			out_beep_q   <= !act_q && chr_q == CH_BEL;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_cursor = out_cursor_q;
	assign out_beep   = out_beep_q;

`ifndef SYNTHESIS
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> cursor_q < CELLS_C)
		else $error("cursor off screen at word accept");

	a_cursor_split: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (col_q < CLW'(COLS) && base_q + CW'(col_q) == cursor_q))
		else $error("row start and column disagree with cursor");

	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_q |-> !(cmd.exec || cmd.clear || cmd.fill || cmd.blank || cmd.sw_write))
		else $error("copy write collides with another write");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear || cmd.fill || cmd.copy || cmd.blank) |-> ctr_q <= end_q)
		else $error("walk counter ran past its end");
`endif

endmodule

[rtl/core/text_console_char_writer.sv]
// Top level of the text console character writer: sequencer plus datapath.
// Uses tccw_pkg, tccw_in_if, tccw_out_if, tccw_ctrl and tccw_dpath.
//
//   channel | dir | handshake      | word
//   req     | in  | valid / ready  | action, char_code, cell_index
//   rsp     | out | valid / ready  | read_data, cursor_pos, beep
//   cfg     | in  | cfg_wr_en      | cfg_addr, cfg_data (write only)
//
// After reset a clearing pass zeroes all ROWS*COLS cells of the screen
// memory (2000 by default); req.ready stays low meanwhile, cfg writes
// are taken. Read, BEL and ignored bytes leave the cursor alone;
// printable, LF, CR, TAB and BS move it and fold each row wrap of the
// column; a scroll moves rows top+1 to bottom up one row when top <
// bottom and blanks the bottom row when it is on screen; FF first fills
// the screen. One word is worked at a time; a finished word waits in
// the result register while the next word is accepted and worked.
`timescale 1ns / 1ps

module text_console_char_writer import tccw_pkg::*; #(
	parameter int ROWS     = TCCW_ROWS,
	parameter int COLS     = TCCW_COLS,
	parameter int TAB_STOP = TCCW_TAB_STOP
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tccw_in_if.sink               req,
	tccw_out_if.source            rsp,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	tccw_cmd_t  cmd;
	tccw_stat_t stat;
	logic       ready;

	// sequencer
	tccw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// screen, cursor and result register
	tccw_dpath #(
		.ROWS     (ROWS),
		.COLS     (COLS),
		.TAB_STOP (TAB_STOP)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_action  (req.action),
		.in_char    (req.char_code),
		.in_index   (req.cell_index),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_data   (rsp.read_data),
		.out_cursor (rsp.cursor_pos),
		.out_beep   (rsp.beep)
	);

	assign req.ready = ready;

endmodule

[tb/tb_text_console_char_writer.sv]
// Self-checking bench for the text console character writer: a directed table, then
// random character and read words across several register settings, checked by a predictor.
// Needs tccw_pkg, tccw_in_if, tccw_out_if and text_console_char_writer.
`timescale 1ns / 1ps

module tb_text_console_char_writer;
	import tccw_pkg::*;

	localparam int ROWS        = TCCW_ROWS;
	localparam int COLS        = TCCW_COLS;
	localparam int TAB_STOP    = TCCW_TAB_STOP;
	localparam int CELLS       = ROWS * COLS;
	localparam int N_DIRECTED  = 22;
	localparam int N_PHASES    = 8;
	localparam int PHASE_WORDS = 200;
	localparam int CYCLE_LIMIT = 15_000_000;

	localparam logic        ACT_PUT  = 1'b0;
	localparam logic        ACT_READ = 1'b1;
	localparam logic [7:0]  CH_NUL   = 8'h00;
	localparam logic [7:0]  CH_ESC   = 8'h1B;
	localparam logic [7:0]  CH_US    = 8'h1F;
	localparam logic [7:0]  CH_A     = 8'h41;
	localparam logic [7:0]  CH_TOP   = 8'hFF;

	// one result word as the block reports it
	typedef struct packed {
		logic [DATA_W-1:0]  data;
		logic [INDEX_W-1:0] cursor;
		logic               beep;
	} console_word_t;

	// directed row: input word plus an optional hand-typed result
	typedef struct packed {
		logic               act;
		logic [CHAR_W-1:0]  ch;
		logic [INDEX_W-1:0] idx;
		logic               typed;
		console_word_t      res;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;

	tccw_in_if  req ();
	tccw_out_if rsp ();

	text_console_char_writer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	// shadow screen, cursor and registers
	logic [DATA_W-1:0] shadow_cells [CELLS];
	int unsigned       shadow_cursor;
	logic [ATTR_W-1:0] shadow_char_attr;
	logic [ATTR_W-1:0] shadow_normal_attr;
	logic [ROW_W-1:0]  shadow_top;
	logic [ROW_W-1:0]  shadow_bot;

	console_word_t pending_results [$];
	console_word_t exp_w;

	int  error_count;
	int  results_checked;
	int  words_sent;
	int  reads_sent;
	int  scroll_count;
	int  fill_count;
	int  settings_count;
	int  cycle_count;
	int  ready_run;
	bit  idle_on;

	// F=D+R packed as {fg, bg}: bits 7 and 3 stay, the 3-bit colors trade places
	function automatic logic [ATTR_W-1:0] flip_colors(input logic [ATTR_W-1:0] a);
		return {a[7], a[2:0], a[3], a[6:4]};
	endfunction

	function automatic void flip_cell(input int unsigned pos);
		if (pos < CELLS) begin
			shadow_cells[pos][15:8] = flip_colors(shadow_cells[pos][15:8]);
		end
	endfunction

	// move the region up one row and blank its bottom row
	function automatic void scroll_up();
		int unsigned lo_cell;
		int unsigned hi_cell;
		int unsigned k;
		lo_cell = shadow_top * COLS;
		hi_cell = shadow_bot * COLS;
		if (shadow_top < shadow_bot) begin
			for (k = lo_cell; k < hi_cell; k++) begin
				if (k + COLS < CELLS) begin
					shadow_cells[k] = shadow_cells[k + COLS];
				end
			end
		end
		if (shadow_bot < ROWS) begin
			for (k = 0; k < COLS; k++) begin
				shadow_cells[hi_cell + k] = {shadow_normal_attr, CH_SPACE};
			end
		end
		scroll_count++;
	endfunction

	// apply one word to the shadow state and return the result it gives
	function automatic console_word_t apply_word(input logic act, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx);
		console_word_t w;
		logic          moved;
		int unsigned   k;
		w = '0;
		moved = 1'b1;
		if (act == ACT_READ) begin
			moved = 1'b0;
			if (idx < CELLS) begin
				w.data = shadow_cells[idx];
			end
		end else if (ch >= CH_SPACE) begin
			if (shadow_cursor < CELLS) begin
				shadow_cells[shadow_cursor] = {shadow_char_attr, ch};
			end
			shadow_cursor++;
		end else begin
			case (ch)
				CH_BEL: begin
					w.beep = 1'b1;
					moved = 1'b0;
				end
				CH_LF: begin
					flip_cell(shadow_cursor);
					shadow_cursor += COLS;
				end
				CH_CR: begin
					flip_cell(shadow_cursor);
					shadow_cursor = shadow_cursor / COLS * COLS;
				end
				CH_TAB: begin
					flip_cell(shadow_cursor);
					shadow_cursor = (shadow_cursor + TAB_STOP) / TAB_STOP * TAB_STOP;
				end
				CH_BS: begin
					if (shadow_cursor == 0) begin
						moved = 1'b0;
					end else begin
						flip_cell(shadow_cursor);
						shadow_cursor--;
					end
				end
				CH_FF: begin
					for (k = 0; k < CELLS; k++) begin
						shadow_cells[k] = {shadow_char_attr, CH_SPACE};
					end
					shadow_cursor = 0;
					fill_count++;
				end
				default: begin
					moved = 1'b0;
				end
			endcase
		end
		if (moved) begin
			while (shadow_cursor >= CELLS) begin
				scroll_up();
				shadow_cursor -= COLS;
			end
			flip_cell(shadow_cursor);
		end
		w.cursor = shadow_cursor[INDEX_W-1:0];
		return w;
	endfunction

	// directed table, run on reset register values
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{ACT_READ, CH_NUL,   11'd0,    1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{ACT_READ, CH_TOP,   11'd2047, 1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{ACT_READ, CH_NUL,   11'd1999, 1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{ACT_PUT,  CH_BEL,   11'd0,    1'b1, '{16'h0000, 11'd0, 1'b1}},
		'{ACT_PUT,  CH_BS,    11'd0,    1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{ACT_PUT,  CH_ESC,   11'd2047, 1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{ACT_PUT,  CH_NUL,   11'd0,    1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{ACT_PUT,  CH_SPACE, 11'd0,    1'b1, '{16'h0000, 11'd1, 1'b0}},
		'{ACT_PUT,  CH_TOP,   11'd0,    1'b1, '{16'h0000, 11'd2, 1'b0}},
		'{ACT_READ, CH_NUL,   11'd0,    1'b1, '{16'h0720, 11'd2, 1'b0}},
		'{ACT_READ, CH_NUL,   11'd1,    1'b1, '{16'h07FF, 11'd2, 1'b0}},
		'{ACT_PUT,  CH_TAB,   11'd0,    1'b1, '{16'h0000, 11'd8, 1'b0}},
		'{ACT_PUT,  CH_A,     11'd0,    1'b0, '0},
		'{ACT_PUT,  CH_LF,    11'd0,    1'b0, '0},
		'{ACT_PUT,  CH_CR,    11'd0,    1'b0, '0},
		'{ACT_PUT,  CH_BS,    11'd0,    1'b0, '0},
		'{ACT_PUT,  CH_FF,    11'd0,    1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{ACT_READ, CH_NUL,   11'd0,    1'b1, '{16'h7020, 11'd0, 1'b0}},
		'{ACT_READ, CH_NUL,   11'd1999, 1'b1, '{16'h0720, 11'd0, 1'b0}},
		'{ACT_READ, CH_NUL,   11'd2000, 1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{ACT_PUT,  CH_CR,    11'd0,    1'b0, '0},
		'{ACT_PUT,  CH_US,    11'd0,    1'b0, '0}
	};

	// send one word at a falling edge; predicted when the handshake happens
	task automatic send_word(input logic act, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx, input logic typed, input console_word_t typed_res);
		console_word_t w;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.action     <= act;
		req.char_code  <= ch;
		req.cell_index <= idx;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		w = apply_word(act, ch, idx);
		pending_results.push_back(typed ? typed_res : w);
		words_sent++;
		if (act == ACT_READ) reads_sent++;
		@(negedge clk);
	endtask

	// pick a random word: mostly text, some controls, reads near the cursor and out of range
	task automatic pick_word(output logic act, output logic [CHAR_W-1:0] ch,
			output logic [INDEX_W-1:0] idx);
		int r;
		int sel;
		r   = $urandom_range(0, 99);
		act = ACT_PUT;
		ch  = CHAR_W'($urandom_range(0, 255));
		idx = INDEX_W'($urandom_range(0, 2047));
		if (r < 28) begin
			act = ACT_READ;
			sel = $urandom_range(0, 5);
			if (sel < 2)
				idx = INDEX_W'((shadow_cursor + $urandom_range(0, 3) + 2047) % 2048);
			else if (sel == 2)
				idx = INDEX_W'($urandom_range(CELLS, 2047));
			else if (sel == 3)
				idx = INDEX_W'($urandom_range(0, 2047));
			else
				idx = INDEX_W'($urandom_range(0, CELLS - 1));
		end else if (r < 68) begin
			ch = CHAR_W'($urandom_range(CH_SPACE, 255));
		end else if (r < 74) begin
			ch = CH_LF;
		end else if (r < 78) begin
			ch = CH_CR;
		end else if (r < 83) begin
			ch = CH_TAB;
		end else if (r < 88) begin
			ch = CH_BS;
		end else if (r < 91) begin
			ch = CH_BEL;
		end else if (r < 92) begin
			ch = CH_FF;
		end else if (r < 94) begin
			ch = CH_ESC;
		end else begin
			ch = CHAR_W'($urandom_range(0, CH_SPACE - 1));
		end
	endtask

	// register write at a falling edge, taken at the next rising edge
	task automatic write_register(input logic [CFG_IDX_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= val;
		@(negedge clk);
		case (addr)
			REG_CHAR_ATTR:   shadow_char_attr   = val;
			REG_NORMAL_ATTR: shadow_normal_attr = val;
			REG_SCROLL_TOP:  shadow_top         = val[ROW_W-1:0];
			REG_SCROLL_BOT:  shadow_bot         = val[ROW_W-1:0];
			default: ;
		endcase
	endtask

	// row registers get random spare upper bits, which the block drops
	task automatic apply_settings(input int char_attr, input int normal_attr,
			input int top_row, input int bot_row);
		logic [CFG_DATA_W-1:0] top_byte;
		logic [CFG_DATA_W-1:0] bot_byte;
		top_byte = {3'($urandom_range(0, 7)), 5'(top_row)};
		bot_byte = {3'($urandom_range(0, 7)), 5'(bot_row)};
		write_register(REG_CHAR_ATTR, 8'(char_attr));
		write_register(REG_NORMAL_ATTR, 8'(normal_attr));
		write_register(REG_SCROLL_TOP, top_byte);
		write_register(REG_SCROLL_BOT, bot_byte);
		cfg_wr_en <= 1'b0;
		settings_count++;
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run length guard
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run hit the cycle limit with %0d results outstanding",
			$time, pending_results.size());
		$display("tb_text_console_char_writer: errors");
		$finish;
	end

	// result side back-pressure: random stall bursts and ready runs
	initial begin
		rsp.ready = 1'b0;
		ready_run = 0;
		forever begin
			@(negedge clk);
			if (!idle_on) begin
				rsp.ready <= 1'b1;
			end else if (ready_run > 0) begin
				ready_run--;
			end else if ($urandom_range(0, 2) == 0) begin
				rsp.ready <= 1'b0;
				ready_run = $urandom_range(1, 11) - 1;
			end else begin
				rsp.ready <= 1'b1;
				ready_run = $urandom_range(1, 24) - 1;
			end
		end
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: data %h cursor %0d beep %b",
					$time, rsp.read_data, rsp.cursor_pos, rsp.beep);
				error_count++;
			end else begin
				exp_w = pending_results.pop_front();
				results_checked++;
				if (rsp.read_data !== exp_w.data) begin
					$display("%0t: read_data expected %h got %h",
						$time, exp_w.data, rsp.read_data);
					error_count++;
				end
				if (rsp.cursor_pos !== exp_w.cursor) begin
					$display("%0t: cursor_pos expected %0d got %0d",
						$time, exp_w.cursor, rsp.cursor_pos);
					error_count++;
				end
				if (rsp.beep !== exp_w.beep) begin
					$display("%0t: beep expected %b got %b", $time, exp_w.beep, rsp.beep);
					error_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic               act;
		logic [CHAR_W-1:0]  ch;
		logic [INDEX_W-1:0] idx;
		int                 phase;
		int                 n;

		error_count     = 0;
		results_checked = 0;
		words_sent      = 0;
		reads_sent      = 0;
		scroll_count    = 0;
		fill_count      = 0;
		settings_count  = 0;
		idle_on         = 1'b1;

		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_addr       = '0;
		cfg_data       = '0;
		req.valid      = 1'b0;
		req.action     = ACT_PUT;
		req.char_code  = '0;
		req.cell_index = '0;

		for (n = 0; n < CELLS; n++) shadow_cells[n] = '0;
		shadow_cursor      = 0;
		shadow_char_attr   = ATTR_RESET;
		shadow_normal_attr = ATTR_RESET;
		shadow_top         = TOP_RESET;
		shadow_bot         = BOT_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table on reset values
		for (n = 0; n < N_DIRECTED; n++) begin
			send_word(directed_rows[n].act, directed_rows[n].ch, directed_rows[n].idx,
				directed_rows[n].typed, directed_rows[n].res);
		end

		// random phases, one register setting each
		for (phase = 0; phase < N_PHASES; phase++) begin
			req.valid <= 1'b0;
			drain_results();
			case (phase)
				0: apply_settings($urandom_range(0, 255), $urandom_range(0, 255), 0, 24);
				// equal rows: nothing moves, row 0 is blanked
				1: apply_settings(255, 0, 0, 0);
				// inverted region
				2: apply_settings(0, 255, 24, 0);
				// bottom row past the screen
				3: apply_settings($urandom_range(0, 255), $urandom_range(0, 255), 20, 31);
				// whole region past the screen
				4: apply_settings($urandom_range(0, 255), $urandom_range(0, 255), 31, 31);
				5: apply_settings($urandom_range(0, 255), $urandom_range(0, 255), 10, 12);
				6: apply_settings($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 31), $urandom_range(0, 31));
				// last part: reset values again, no idling
				default: begin
					apply_settings(ATTR_RESET, ATTR_RESET, TOP_RESET, BOT_RESET);
					idle_on = 1'b0;
				end
			endcase
			for (n = 0; n < PHASE_WORDS; n++) begin
				pick_word(act, ch, idx);
				send_word(act, ch, idx, 1'b0, '0);
			end
		end
		req.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d words (%0d reads, %0d puts) with %0d scrolls and %0d fills",
			words_sent, reads_sent, words_sent - reads_sent, scroll_count, fill_count);
		$display("over %0d register settings; %0d results checked, %0d mismatches",
			settings_count + 1, results_checked, error_count);
		if (error_count == 0) begin
			$display("tb_text_console_char_writer: clean");
		end else begin
			$display("tb_text_console_char_writer: errors");
		end
		$finish;
	end

endmodule
